/* src/rftp_pkg.sv */
// rftp_pkg: types, codes and constants shared by the radar frame target parser.
// Used by rftp_unpack, rftp_out_buf and radar_frame_target_parser; depends on nothing.

package rftp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } item_t;

  typedef struct packed {
    logic        [1:0]  result_kind;
    logic        [2:0]  error_code;
    logic        [7:0]  target_index;
    logic        [7:0]  target_count;
    logic        [5:0]  target_id;
    logic        [15:0] length_mm;
    logic signed [17:0] speed_x_mms;
    logic signed [17:0] speed_y_mms;
    logic signed [19:0] pos_x_mm;
    logic signed [19:0] pos_y_mm;
  } result_t;

  typedef struct packed {
    logic        [5:0]  target_id;
    logic        [15:0] length_mm;
    logic signed [17:0] speed_x_mms;
    logic signed [17:0] speed_y_mms;
    logic signed [19:0] pos_x_mm;
    logic signed [19:0] pos_y_mm;
  } target_fields_t;

  typedef enum logic [2:0] {
    PH_HUNT_HEAD,
    PH_TAG1,
    PH_TAG2,
    PH_LEN,
    PH_BODY,
    PH_HUNT_TAIL
  } phase_t;

  localparam logic [1:0] KIND_TARGET = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_TAG   = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
  localparam logic [2:0] ERR_TOO_SHORT = 3'd3;
  localparam logic [2:0] ERR_EARLY_END = 3'd4;

  // head is CA CB CC CD, tail is EA EB EC ED
  localparam logic [7:0] HEAD_BASE = 8'hCA;
  localparam logic [7:0] TAIL_BASE = 8'hEA;

  localparam logic [7:0] MIN_BODY_BYTES = 8'd8;

  localparam logic [1:0] LINE_TARGET_COUNT = 2'd2;
  localparam logic [1:0] LINE_TARGETS      = 2'd3;

  function automatic logic [7:0] pre_tag1(input logic [1:0] line_no);
    case (line_no)
      2'd0:    pre_tag1 = 8'h02;
      default: pre_tag1 = 8'h05;
    endcase
  endfunction

  function automatic logic [7:0] pre_tag2(input logic [1:0] line_no);
    case (line_no)
      2'd0:    pre_tag2 = 8'hFF;
      2'd1:    pre_tag2 = 8'h00;
      default: pre_tag2 = 8'h01;
    endcase
  endfunction

endpackage

/* src/rftp_unpack.sv */
// rftp_unpack: unpacks one target line's first eight payload bytes into scaled fields.
// Depends on rftp_pkg for target_fields_t.

module rftp_unpack (
  input  logic [63:0]               window,
  output rftp_pkg::target_fields_t  fields
);

  logic [7:0]         p0, p1, p2, p3, p4, p5, p6, p7;
  logic [7:0]         len_raw;
  logic [10:0]        sx_raw, sy_raw;
  logic [13:0]        px_raw, py_raw;
  logic signed [17:0] sx_ext, sy_ext;

  assign p0 = window[63:56];
  assign p1 = window[55:48];
  assign p2 = window[47:40];
  assign p3 = window[39:32];
  assign p4 = window[31:24];
  assign p5 = window[23:16];
  assign p6 = window[15:8];
  assign p7 = window[7:0];

  assign len_raw = {p0[1:0], p1[7:2]};
  assign sx_raw  = {p3[6:0], p4[7:4]};
  assign sy_raw  = {p1[1:0], p2, p3[7]};
  assign px_raw  = {p6[5:0], p7};
  assign py_raw  = {p4[3:0], p5, p6[7:6]};

  // raw minus half range is the raw value with its top bit inverted, read as signed
  assign sx_ext = 18'(signed'({~sx_raw[10], sx_raw[9:0]}));
  assign sy_ext = 18'(signed'({~sy_raw[10], sy_raw[9:0]}));

  always_comb begin
    fields.target_id   = p0[7:2];
    fields.length_mm   = 16'(len_raw) * 16'd200;
    fields.speed_x_mms = sx_ext * 18'sd100;
    fields.speed_y_mms = sy_ext * 18'sd100;
    // times 64 is a six-bit shift
    fields.pos_x_mm    = {~px_raw[13], px_raw[12:0], 6'b0};
    fields.pos_y_mm    = {~py_raw[13], py_raw[12:0], 6'b0};
  end

endmodule

/* src/rftp_out_buf.sv */
// rftp_out_buf: two-entry result buffer (output register plus skid register).
// Depends on rftp_pkg for result_t.

module rftp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rftp_pkg::result_t push_data,
  output logic              can_push,
  output logic              result_valid,
  input  logic              result_ready,
  output rftp_pkg::result_t result
);

  logic              main_valid, skid_valid;
  rftp_pkg::result_t main_data, skid_data;
  logic              pop;

  assign pop          = main_valid && result_ready;
  assign can_push     = !skid_valid;
  assign result_valid = main_valid;
  assign result       = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held without an output entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into a full buffer");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (pop && skid_valid) |=> (main_valid && !skid_valid))
    else $error("skid entry not moved to output after transfer");

endmodule

/* src/radar_frame_target_parser.sv */
// radar_frame_target_parser: byte-stream parser for radar frames, one target record per target line.
// A result is written into the output buffer on the byte transfer that causes it, and offered on result
// once it reaches the output register. Throughput: one byte per cycle while item_ready is high;
// the two-entry output buffer keeps item_ready high while one result waits and drops it when both are full.
// Reset (rst, synchronous): parser returns to head hunting and the output buffer empties.
// Depends on rftp_pkg, rftp_unpack and rftp_out_buf.

module radar_frame_target_parser #(
  parameter int MAX_LINE_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  rftp_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output rftp_pkg::result_t result
);

  localparam logic [8:0] MAX_LEN = 9'(MAX_LINE_BYTES);

  rftp_pkg::phase_t phase, phase_next;
  logic [1:0]  pm, pm_next;
  logic [7:0]  first_tag, first_tag_next;
  logic [7:0]  line_length, line_length_next;
  logic [7:0]  bytes_in_line, bytes_in_line_next;
  logic [7:0]  targets_expected, targets_expected_next;
  logic [7:0]  targets_done, targets_done_next;
  logic [1:0]  line_no, line_no_next;
  logic [63:0] window, window_next;

  logic        accept;
  logic [7:0]  b;
  logic        head_hit, tail_hit;
  logic [1:0]  head_pm, tail_pm;
  logic        tag_bad, len_long, len_short, line_done, closed;
  logic [7:0]  bil_inc;
  logic        emit_target, emit_status;
  logic [1:0]  status_kind;
  logic [2:0]  status_code;

  logic              push;
  rftp_pkg::result_t push_data;
  rftp_pkg::target_fields_t tfields;

  assign accept = item_valid && item_ready;
  assign b      = item.data_byte;

  // pattern hunt: advance on the expected byte, else restart (count one on the first byte)
  always_comb begin
    head_hit = (pm == 2'd3) && (b == rftp_pkg::HEAD_BASE + 8'd3);
    tail_hit = (pm == 2'd3) && (b == rftp_pkg::TAIL_BASE + 8'd3);
    if (b == rftp_pkg::HEAD_BASE + 8'(pm)) begin
      head_pm = pm + 2'd1;
    end else begin
      head_pm = (b == rftp_pkg::HEAD_BASE) ? 2'd1 : 2'd0;
    end
    if (b == rftp_pkg::TAIL_BASE + 8'(pm)) begin
      tail_pm = pm + 2'd1;
    end else begin
      tail_pm = (b == rftp_pkg::TAIL_BASE) ? 2'd1 : 2'd0;
    end
    tag_bad   = (line_no != rftp_pkg::LINE_TARGETS) &&
                ((first_tag != rftp_pkg::pre_tag1(line_no)) ||
                 (b != rftp_pkg::pre_tag2(line_no)));
    len_long  = {1'b0, b} > MAX_LEN;
    len_short = (line_no >= rftp_pkg::LINE_TARGET_COUNT) && (b < rftp_pkg::MIN_BODY_BYTES);
    bil_inc   = bytes_in_line + 8'd1;
    line_done = ((phase == rftp_pkg::PH_LEN) && !len_long && !len_short && (b == 8'd0)) ||
                ((phase == rftp_pkg::PH_BODY) && (bil_inc >= line_length));
    window_next = ((phase == rftp_pkg::PH_BODY) && (bytes_in_line < 8'd8)) ?
                  {window[55:0], b} : window;
  end

  // next state
  always_comb begin
    phase_next            = phase;
    pm_next               = pm;
    first_tag_next        = first_tag;
    line_length_next      = line_length;
    bytes_in_line_next    = bytes_in_line;
    targets_expected_next = targets_expected;
    targets_done_next     = targets_done;
    line_no_next          = line_no;
    closed                = 1'b0;
    case (phase)
      rftp_pkg::PH_HUNT_HEAD: begin
        pm_next = head_pm;
        if (head_hit) begin
          pm_next               = 2'd0;
          phase_next            = rftp_pkg::PH_TAG1;
          line_no_next          = 2'd0;
          targets_expected_next = 8'd0;
          targets_done_next     = 8'd0;
        end
      end
      rftp_pkg::PH_TAG1: begin
        first_tag_next = b;
        phase_next     = rftp_pkg::PH_TAG2;
      end
      rftp_pkg::PH_TAG2: begin
        if (tag_bad) begin
          closed     = 1'b1;
          phase_next = rftp_pkg::PH_HUNT_HEAD;
          pm_next    = 2'd0;
        end else begin
          phase_next = rftp_pkg::PH_LEN;
        end
      end
      rftp_pkg::PH_LEN: begin
        line_length_next   = b;
        bytes_in_line_next = 8'd0;
        if (len_long || len_short) begin
          closed     = 1'b1;
          phase_next = rftp_pkg::PH_HUNT_HEAD;
          pm_next    = 2'd0;
        end else if (b != 8'd0) begin
          phase_next = rftp_pkg::PH_BODY;
        end
      end
      rftp_pkg::PH_BODY: begin
        bytes_in_line_next = bil_inc;
      end
      rftp_pkg::PH_HUNT_TAIL: begin
        pm_next = tail_pm;
        if (tail_hit) begin
          closed     = 1'b1;
          phase_next = rftp_pkg::PH_HUNT_HEAD;
          pm_next    = 2'd0;
        end
      end
      default: begin
        phase_next = rftp_pkg::PH_HUNT_HEAD;
        pm_next    = 2'd0;
      end
    endcase

    // end of line
    if (line_done) begin
      if (line_no < rftp_pkg::LINE_TARGET_COUNT) begin
        line_no_next = line_no + 2'd1;
        phase_next   = rftp_pkg::PH_TAG1;
      end else if (line_no == rftp_pkg::LINE_TARGET_COUNT) begin
        targets_expected_next = window_next[7:0];
        targets_done_next     = 8'd0;
        line_no_next          = rftp_pkg::LINE_TARGETS;
        pm_next               = 2'd0;
        phase_next            = (window_next[7:0] == 8'd0) ? rftp_pkg::PH_HUNT_TAIL
                                                           : rftp_pkg::PH_TAG1;
      end else begin
        targets_done_next = targets_done + 8'd1;
        if (targets_done + 8'd1 == targets_expected) begin
          phase_next = rftp_pkg::PH_HUNT_TAIL;
          pm_next    = 2'd0;
        end else begin
          phase_next = rftp_pkg::PH_TAG1;
        end
      end
    end

    if (item.buffer_end) begin
      phase_next = rftp_pkg::PH_HUNT_HEAD;
      pm_next    = 2'd0;
    end
  end

  // phase after the byte, before the buffer-end override
  function automatic rftp_pkg::phase_t phase_next_pre_end();
    rftp_pkg::phase_t ph;
    ph = phase;
    case (phase)
      rftp_pkg::PH_HUNT_HEAD: ph = head_hit ? rftp_pkg::PH_TAG1 : rftp_pkg::PH_HUNT_HEAD;
      rftp_pkg::PH_TAG1:      ph = rftp_pkg::PH_TAG2;
      rftp_pkg::PH_TAG2:      ph = tag_bad ? rftp_pkg::PH_HUNT_HEAD : rftp_pkg::PH_LEN;
      rftp_pkg::PH_LEN:       ph = (len_long || len_short) ? rftp_pkg::PH_HUNT_HEAD
                                                           : rftp_pkg::PH_BODY;
      rftp_pkg::PH_HUNT_TAIL: ph = tail_hit ? rftp_pkg::PH_HUNT_HEAD : rftp_pkg::PH_HUNT_TAIL;
      default:                ph = phase;
    endcase
    // a finished line never leads back to head hunting
    if (line_done) begin
      ph = rftp_pkg::PH_TAG1;
    end
    return ph;
  endfunction

  // result selection
  always_comb begin
    emit_target = 1'b0;
    emit_status = 1'b0;
    status_kind = rftp_pkg::KIND_ERROR;
    status_code = rftp_pkg::ERR_NONE;
    case (phase)
      rftp_pkg::PH_TAG2: begin
        if (tag_bad) begin
          emit_status = 1'b1;
          status_code = rftp_pkg::ERR_BAD_TAG;
        end
      end
      rftp_pkg::PH_LEN: begin
        if (len_long) begin
          emit_status = 1'b1;
          status_code = rftp_pkg::ERR_TOO_LONG;
        end else if (len_short) begin
          emit_status = 1'b1;
          status_code = rftp_pkg::ERR_TOO_SHORT;
        end
      end
      rftp_pkg::PH_HUNT_TAIL: begin
        if (tail_hit) begin
          emit_status = 1'b1;
          status_kind = rftp_pkg::KIND_FRAME;
        end
      end
      default: begin
        emit_status = 1'b0;
      end
    endcase
    if (line_done && (line_no == rftp_pkg::LINE_TARGETS)) begin
      emit_target = 1'b1;
    end
    // early end of buffer replaces a target record from the same byte
    if (item.buffer_end && !closed &&
        ((phase_next_pre_end() != rftp_pkg::PH_HUNT_HEAD))) begin
      emit_target = 1'b0;
      emit_status = 1'b1;
      status_kind = rftp_pkg::KIND_ERROR;
      status_code = rftp_pkg::ERR_EARLY_END;
    end
  end

  rftp_unpack u_unpack (
    .window (window_next),
    .fields (tfields)
  );

  always_comb begin
    push = accept && (emit_target || emit_status);
    push_data.result_kind  = emit_target ? rftp_pkg::KIND_TARGET : status_kind;
    push_data.error_code   = emit_target ? rftp_pkg::ERR_NONE : status_code;
    push_data.target_index = emit_target ? targets_done : targets_done_next;
    push_data.target_count = targets_expected_next;
    push_data.target_id    = emit_target ? tfields.target_id   : 6'd0;
    push_data.length_mm    = emit_target ? tfields.length_mm   : 16'd0;
    push_data.speed_x_mms  = emit_target ? tfields.speed_x_mms : 18'sd0;
    push_data.speed_y_mms  = emit_target ? tfields.speed_y_mms : 18'sd0;
    push_data.pos_x_mm     = emit_target ? tfields.pos_x_mm    : 20'sd0;
    push_data.pos_y_mm     = emit_target ? tfields.pos_y_mm    : 20'sd0;
  end

  rftp_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_data    (push_data),
    .can_push     (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= rftp_pkg::PH_HUNT_HEAD;
      pm               <= 2'd0;
      first_tag        <= 8'd0;
      line_length      <= 8'd0;
      bytes_in_line    <= 8'd0;
      targets_expected <= 8'd0;
      targets_done     <= 8'd0;
      line_no          <= 2'd0;
    end else if (accept) begin
      phase            <= phase_next;
      pm               <= pm_next;
      first_tag        <= first_tag_next;
      line_length      <= line_length_next;
      bytes_in_line    <= bytes_in_line_next;
      targets_expected <= targets_expected_next;
      targets_done     <= targets_done_next;
      line_no          <= line_no_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

  a_body_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == rftp_pkg::PH_BODY) |-> (bytes_in_line < line_length))
    else $error("payload byte count ran past the line length");

  a_match_only_hunting: assert property (@(posedge clk) disable iff (rst)
    ((phase != rftp_pkg::PH_HUNT_HEAD) && (phase != rftp_pkg::PH_HUNT_TAIL)) |-> (pm == 2'd0))
    else $error("pattern match count left over outside a hunt");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("waiting result changed before its transfer");

endmodule

/* tb/sv/radar_frame_target_parser_tb.sv */
// radar_frame_target_parser_tb: self-checking bench for the radar frame target parser.
// Feeds directed and random capture bytes, predicts every record in its own parser model.
// Depends on rftp_pkg and radar_frame_target_parser.

module radar_frame_target_parser_tb;

  localparam int MAX_LINE = 32;
  localparam int TOTAL_BYTES = 750;

  localparam int FAULT_NONE  = 0;
  localparam int FAULT_TAG   = 1;
  localparam int FAULT_LONG  = 2;
  localparam int FAULT_SHORT = 3;
  localparam int FAULT_TRUNC = 4;
  localparam int FAULT_FLIP  = 5;

  localparam int NO_FILL  = -1;
  localparam int NO_COUNT = -1;
  localparam int NO_END   = -1;

  logic              clk;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  rftp_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  rftp_pkg::result_t result;

  radar_frame_target_parser dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("parser run timed out");
    $display("radar_frame_target_parser_tb: errors");
    $finish;
  end

  // parser model state
  rftp_pkg::phase_t ph = rftp_pkg::PH_HUNT_HEAD;
  logic [2:0]  matched = '0;
  logic [7:0]  tag_first = '0;
  logic [7:0]  line_len = '0;
  logic [7:0]  line_pos = '0;
  logic [7:0]  tgt_total = '0;
  logic [7:0]  tgt_done = '0;
  logic [63:0] window = '0;
  logic [1:0]  line_idx = '0;
  logic [7:0]  tag_hi [3] = '{8'h02, 8'h05, 8'h05};
  logic [7:0]  tag_lo [3] = '{8'hFF, 8'h00, 8'h01};

  rftp_pkg::result_t expected_records [$];
  logic [7:0] frame_buf [$];
  bit         idle_on = 1'b0;
  int         error_count = 0;
  int         records_checked = 0;
  int         bytes_sent = 0;
  int         targets_seen = 0;
  int         frames_seen = 0;
  int         aborts_seen = 0;
  int         stall_left = 0;

  function automatic logic [2:0] next_match(input logic [7:0] base, input logic [7:0] b);
    if (b == base + 8'(matched[1:0])) return {1'b0, matched[1:0]} + 3'd1;
    return (b == base) ? 3'd1 : 3'd0;
  endfunction

  function automatic void go_hunt();
    ph = rftp_pkg::PH_HUNT_HEAD;
    matched = '0;
  endfunction

  function automatic rftp_pkg::result_t status_record(input logic [1:0] kind,
                                                      input logic [2:0] code);
    rftp_pkg::result_t r;
    r = '0;
    r.result_kind = kind;
    r.error_code = code;
    r.target_index = tgt_done;
    r.target_count = tgt_total;
    return r;
  endfunction

  function automatic rftp_pkg::result_t target_record();
    logic [7:0]  p [8];
    logic [7:0]  len_raw;
    logic [10:0] sx, sy;
    logic [13:0] px, py;
    rftp_pkg::result_t r;
    for (int k = 0; k < 8; k++) p[k] = window[63 - 8 * k -: 8];
    len_raw = {p[0][1:0], p[1][7:2]};
    sx = {p[3][6:0], p[4][7:4]};
    sy = {p[1][1:0], p[2], p[3][7]};
    px = {p[6][5:0], p[7]};
    py = {p[4][3:0], p[5], p[6][7:6]};
    r = status_record(rftp_pkg::KIND_TARGET, rftp_pkg::ERR_NONE);
    r.target_id = p[0][7:2];
    r.length_mm = 16'(int'(len_raw) * 200);
    r.speed_x_mms = 18'((int'(sx) - 1024) * 100);
    r.speed_y_mms = 18'((int'(sy) - 1024) * 100);
    r.pos_x_mm = 20'((int'(px) - 8192) * 64);
    r.pos_y_mm = 20'((int'(py) - 8192) * 64);
    return r;
  endfunction

  function automatic bit close_line(output rftp_pkg::result_t r);
    r = '0;
    if (line_idx < rftp_pkg::LINE_TARGET_COUNT) begin
      line_idx++;
      ph = rftp_pkg::PH_TAG1;
      return 1'b0;
    end
    if (line_idx == rftp_pkg::LINE_TARGET_COUNT) begin
      // target count sits in payload byte 7 of the 05 01 line
      tgt_total = window[7:0];
      tgt_done = '0;
      line_idx = rftp_pkg::LINE_TARGETS;
      ph = (tgt_total == 8'd0) ? rftp_pkg::PH_HUNT_TAIL : rftp_pkg::PH_TAG1;
      matched = '0;
      return 1'b0;
    end
    r = target_record();
    tgt_done++;
    if (tgt_done == tgt_total) begin
      ph = rftp_pkg::PH_HUNT_TAIL;
      matched = '0;
    end else begin
      ph = rftp_pkg::PH_TAG1;
    end
    return 1'b1;
  endfunction

  function automatic void predict_parse(input logic [7:0] b, input logic last);
    rftp_pkg::result_t r;
    bit      have;
    bit      closed;
    r = '0;
    have = 1'b0;
    closed = 1'b0;
    case (ph)
      rftp_pkg::PH_HUNT_HEAD: begin
        matched = next_match(rftp_pkg::HEAD_BASE, b);
        if (matched == 3'd4) begin
          matched = '0;
          ph = rftp_pkg::PH_TAG1;
          line_idx = '0;
          tgt_total = '0;
          tgt_done = '0;
        end
      end
      rftp_pkg::PH_TAG1: begin
        tag_first = b;
        ph = rftp_pkg::PH_TAG2;
      end
      rftp_pkg::PH_TAG2: begin
        if (line_idx != rftp_pkg::LINE_TARGETS &&
            (tag_first != tag_hi[line_idx] || b != tag_lo[line_idx])) begin
          r = status_record(rftp_pkg::KIND_ERROR, rftp_pkg::ERR_BAD_TAG);
          have = 1'b1;
          closed = 1'b1;
          go_hunt();
        end else begin
          ph = rftp_pkg::PH_LEN;
        end
      end
      rftp_pkg::PH_LEN: begin
        line_len = b;
        line_pos = '0;
        if (b > MAX_LINE) begin
          r = status_record(rftp_pkg::KIND_ERROR, rftp_pkg::ERR_TOO_LONG);
          have = 1'b1;
          closed = 1'b1;
          go_hunt();
        end else if (line_idx >= rftp_pkg::LINE_TARGET_COUNT &&
                     b < rftp_pkg::MIN_BODY_BYTES) begin
          r = status_record(rftp_pkg::KIND_ERROR, rftp_pkg::ERR_TOO_SHORT);
          have = 1'b1;
          closed = 1'b1;
          go_hunt();
        end else if (b == 8'd0) begin
          have = close_line(r);
        end else begin
          ph = rftp_pkg::PH_BODY;
        end
      end
      rftp_pkg::PH_BODY: begin
        if (line_pos < 8'd8) window = {window[55:0], b};
        line_pos++;
        if (line_pos >= line_len) have = close_line(r);
      end
      rftp_pkg::PH_HUNT_TAIL: begin
        matched = next_match(rftp_pkg::TAIL_BASE, b);
        if (matched == 3'd4) begin
          r = status_record(rftp_pkg::KIND_FRAME, rftp_pkg::ERR_NONE);
          have = 1'b1;
          closed = 1'b1;
          go_hunt();
        end
      end
      default: go_hunt();
    endcase
    // an open frame cut by the buffer end overrides any record from this byte
    if (last) begin
      if (!closed && ph != rftp_pkg::PH_HUNT_HEAD) begin
        r = status_record(rftp_pkg::KIND_ERROR, rftp_pkg::ERR_EARLY_END);
        have = 1'b1;
      end
      go_hunt();
    end
    if (have) expected_records.push_back(r);
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < 100) $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [19:0] got, input logic [19:0] want);
    if (got !== want)
      flag_error($sformatf("record %0d %s: got %0h want %0h", records_checked, name, got, want));
  endtask

  // result side backpressure in random bursts, started only while idle_on is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rftp_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_records.size() == 0) begin
        flag_error($sformatf("unexpected result kind %0d code %0d",
                             result.result_kind, result.error_code));
      end else begin
        want = expected_records.pop_front();
        check_field("result_kind", 20'(result.result_kind), 20'(want.result_kind));
        check_field("error_code", 20'(result.error_code), 20'(want.error_code));
        check_field("target_index", 20'(result.target_index), 20'(want.target_index));
        check_field("target_count", 20'(result.target_count), 20'(want.target_count));
        check_field("target_id", 20'(result.target_id), 20'(want.target_id));
        check_field("length_mm", 20'(result.length_mm), 20'(want.length_mm));
        check_field("speed_x_mms", 20'(result.speed_x_mms), 20'(want.speed_x_mms));
        check_field("speed_y_mms", 20'(result.speed_y_mms), 20'(want.speed_y_mms));
        check_field("pos_x_mm", result.pos_x_mm, want.pos_x_mm);
        check_field("pos_y_mm", result.pos_y_mm, want.pos_y_mm);
        records_checked++;
        case (want.result_kind)
          rftp_pkg::KIND_TARGET: targets_seen++;
          rftp_pkg::KIND_FRAME:  frames_seen++;
          default:               aborts_seen++;
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item <= '{data_byte: b, buffer_end: last};
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    predict_parse(b, last);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_head();
    for (int k = 0; k < 4; k++) frame_buf.push_back(rftp_pkg::HEAD_BASE + 8'(k));
  endtask

  task automatic add_tail();
    for (int k = 0; k < 4; k++) frame_buf.push_back(rftp_pkg::TAIL_BASE + 8'(k));
  endtask

  task automatic add_line(input logic [7:0] t1, t2, len, input int fill, input int count_byte);
    frame_buf.push_back(t1);
    frame_buf.push_back(t2);
    frame_buf.push_back(len);
    for (int i = 0; i < len && i < MAX_LINE; i++) begin
      if (i == 7 && count_byte >= 0) frame_buf.push_back(8'(count_byte));
      else if (fill >= 0) frame_buf.push_back(8'(fill));
      else frame_buf.push_back(8'($urandom));
    end
  endtask

  task automatic add_preamble(input int count, input logic [7:0] len0, len1, len2);
    add_line(8'h02, 8'hFF, len0, NO_FILL, NO_COUNT);
    add_line(8'h05, 8'h00, len1, NO_FILL, NO_COUNT);
    add_line(8'h05, 8'h01, len2, NO_FILL, count);
  endtask

  // end_pos marks the byte that carries the buffer end; the rest is dropped
  task automatic send_buf(input int end_pos);
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == end_pos);
      if (i == end_pos) break;
    end
    frame_buf.delete();
  endtask

  task automatic test_clean_frame();
    add_head();
    add_preamble(2, 8'd0, 8'd3, 8'd8);
    add_line(8'h11, 8'h22, 8'd8, 8'hFF, NO_COUNT);
    add_line(8'h00, 8'h00, 8'd8, 8'h00, NO_COUNT);
    add_tail();
    send_buf(NO_END);
    wait_drained();
  endtask

  task automatic test_hunting();
    send_byte(8'h00, 1'b1);
    frame_buf.push_back(rftp_pkg::HEAD_BASE);
    frame_buf.push_back(rftp_pkg::HEAD_BASE + 8'd1);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(rftp_pkg::HEAD_BASE);
    add_head();
    // zero targets: straight to the tail hunt, line bytes there are ignored
    add_preamble(0, 8'd1, 8'd0, 8'd8);
    add_line(8'h05, 8'h01, 8'd2, NO_FILL, NO_COUNT);
    frame_buf.push_back(rftp_pkg::TAIL_BASE);
    add_tail();
    send_buf(frame_buf.size() - 1);
    wait_drained();
  endtask

  task automatic test_line_faults();
    add_head();
    add_line(8'h02, 8'hFE, 8'd0, NO_FILL, NO_COUNT);
    add_head();
    add_line(8'h02, 8'hFF, 8'd32, NO_FILL, NO_COUNT);
    add_line(8'h05, 8'h00, 8'd0, NO_FILL, NO_COUNT);
    add_line(8'h05, 8'h02, 8'd8, NO_FILL, NO_COUNT);
    add_head();
    frame_buf.push_back(8'h02);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'd33);
    add_head();
    add_line(8'h02, 8'hFF, 8'd0, NO_FILL, NO_COUNT);
    add_line(8'h05, 8'h00, 8'd0, NO_FILL, NO_COUNT);
    frame_buf.push_back(8'h05);
    frame_buf.push_back(8'h01);
    frame_buf.push_back(8'd7);
    add_head();
    add_preamble(3, 8'd0, 8'd0, 8'd8);
    add_line(8'hAB, 8'hCD, 8'd9, NO_FILL, NO_COUNT);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'd5);
    add_head();
    add_preamble(1, 8'd0, 8'd0, 8'd8);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    send_buf(NO_END);
    wait_drained();
  endtask

  task automatic test_buffer_end();
    add_head();
    add_line(8'h02, 8'hFF, 8'd4, NO_FILL, NO_COUNT);
    send_buf(6);
    add_head();
    send_buf(3);
    // buffer end on the last byte of the last target replaces its record
    add_head();
    add_preamble(1, 8'd0, 8'd0, 8'd8);
    add_line(8'h01, 8'h02, 8'd8, NO_FILL, NO_COUNT);
    send_buf(frame_buf.size() - 1);
    add_head();
    add_preamble(255, 8'd0, 8'd0, 8'd10);
    add_line(8'h01, 8'h02, 8'd8, NO_FILL, NO_COUNT);
    add_line(8'h03, 8'h04, 8'd8, NO_FILL, NO_COUNT);
    send_buf(frame_buf.size() - 2);
    wait_drained();
  endtask

  task automatic random_frame();
    int         n_tgt;
    int         fault;
    int         fault_line;
    int         end_pos;
    logic [7:0] t1, t2, len;
    n_tgt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
    fault = $urandom_range(0, 11);
    if (fault > FAULT_FLIP) fault = FAULT_NONE;
    fault_line = $urandom_range(0, 2 + n_tgt);
    end_pos = NO_END;
    repeat ($urandom_range(0, 4)) frame_buf.push_back(8'($urandom));
    add_head();
    for (int k = 0; k < 3 + n_tgt; k++) begin
      t1 = (k < 3) ? tag_hi[k] : 8'($urandom);
      t2 = (k < 3) ? tag_lo[k] : 8'($urandom);
      if (k < 2) len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, MAX_LINE))
                                                    : 8'($urandom_range(0, 6));
      else len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8, MAX_LINE))
                                             : 8'($urandom_range(8, 11));
      if (k == fault_line) begin
        case (fault)
          FAULT_TAG:   if ($urandom_range(0, 1) == 0) t1 ^= 8'($urandom_range(1, 255));
                       else t2 ^= 8'($urandom_range(1, 255));
          FAULT_LONG:  len = 8'($urandom_range(MAX_LINE + 1, 255));
          FAULT_SHORT: len = 8'($urandom_range(0, 7));
          default: ;
        endcase
      end
      add_line(t1, t2, len, NO_FILL, (k == 2) ? n_tgt : NO_COUNT);
    end
    repeat ($urandom_range(0, 3)) frame_buf.push_back(8'($urandom));
    add_tail();
    if (fault == FAULT_TRUNC) end_pos = $urandom_range(0, frame_buf.size() - 1);
    else if (fault == FAULT_FLIP)
      frame_buf[$urandom_range(0, frame_buf.size() - 1)] ^= 8'($urandom_range(1, 255));
    else if ($urandom_range(0, 4) == 0) end_pos = frame_buf.size() - 1;
    // stray buffer end outside any frame
    if ($urandom_range(0, 7) == 0) send_byte(8'($urandom), 1'b1);
    send_buf(end_pos);
  endtask

  task automatic test_random_frames();
    idle_on = 1'b1;
    while (bytes_sent < TOTAL_BYTES) begin
      // the last stretch runs with no idling on either side
      if (bytes_sent > TOTAL_BYTES * 2 / 3) idle_on = 1'b0;
      random_frame();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    idle_on = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_clean_frame();
    idle_on = 1'b1;
    test_hunting();
    test_line_faults();
    test_buffer_end();
    idle_on = 1'b0;
    test_random_frames();
    repeat (10) @(posedge clk);
    $display("covered %0d capture bytes: %0d target records, %0d complete frames, %0d errors",
             bytes_sent, targets_seen, frames_seen, aborts_seen);
    $display("head/tail hunting, tag and length faults, buffer ends, random stalls and gaps");
    if (error_count == 0 && expected_records.size() == 0) begin
      $display("radar_frame_target_parser_tb: clean");
    end else begin
      $display("radar_frame_target_parser_tb: errors");
    end
    $finish;
  end

endmodule
